FILE: rtl/core/hdma_pkg.sv
`default_nettype none

package hdma_pkg;

  localparam int unsigned CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_TRANSFER_MODE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INDIRECT_MODE = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_REGISTER_BASE = 2'd2;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_LINE  = 2'd2;

  localparam logic [1:0] RD_TABLE = 2'd0;
  localparam logic [1:0] RD_DATA  = 2'd1;
  localparam logic [1:0] RD_FRESH = 2'd2;

  localparam logic [13:0] REG_PAGE = 14'h2100;

  typedef struct packed {
    logic       mem_we;
    logic       start;
    logic       stop;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       count_load;
    logic       count_dec;
    logic       lo_load;
    logic       out_load;
    logic       out_last;
    logic [1:0] wr_idx;
  } hdma_cmd_t;

  typedef struct packed {
    logic       running;
    logic [7:0] count;
    logic       rdata_zero;
    logic       indirect;
    logic [2:0] mode;
    logic       out_free;
  } hdma_status_t;

  function automatic logic [2:0] write_count(input logic [2:0] mode);
    logic [2:0] n;
    case (mode)
      3'd0:    n = 3'd1;
      3'd1:    n = 3'd2;
      3'd2:    n = 3'd2;
      3'd6:    n = 3'd2;
      default: n = 3'd4;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] reg_offset(input logic [2:0] mode, input logic [1:0] idx);
    logic [1:0] off;
    case (mode)
      3'd1:    off = {1'b0, idx[0]};
      3'd3:    off = {1'b0, idx[1]};
      3'd4:    off = idx;
      3'd5:    off = {1'b0, idx[0]};
      3'd7:    off = {1'b0, idx[1]};
      default: off = 2'd0;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hdma_ctrl.sv
`default_nettype none

module hdma_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            req_type,
  input  wire logic                  channel_active,
  input  wire hdma_pkg::hdma_status_t st,
  output hdma_pkg::hdma_cmd_t        cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CNT     = 3'd1;
  localparam logic [2:0] S_CNT_CHK = 3'd2;
  localparam logic [2:0] S_PLO     = 3'd3;
  localparam logic [2:0] S_PHI     = 3'd4;
  localparam logic [2:0] S_XFER    = 3'd5;
  localparam logic [2:0] S_WR      = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] idx;
  logic [1:0] idx_next;
  logic [2:0] cnt;
  logic       last;
  logic [1:0] data_sel;

  assign in_ready = (state == S_IDLE);
  assign cnt      = hdma_pkg::write_count(st.mode);
  assign last     = ({1'b0, idx} + 3'd1) == cnt;
  assign data_sel = st.indirect ? hdma_pkg::RD_DATA : hdma_pkg::RD_TABLE;

  always_comb begin
    cmd        = '0;
    cmd.wr_idx = idx;
    state_next = state;
    idx_next   = idx;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (req_type)
            hdma_pkg::REQ_LOAD: begin
              cmd.mem_we = 1'b1;
            end
            hdma_pkg::REQ_START: begin
              if (channel_active) begin
                cmd.start = 1'b1;
              end else begin
                cmd.stop = 1'b1;
              end
            end
            hdma_pkg::REQ_LINE: begin
              if (st.running) begin
                if (st.count[6:0] == 7'd0) begin
                  state_next = S_CNT;
                end else if (st.count[7]) begin
                  state_next = S_XFER;
                end else begin
                  cmd.count_dec = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_CNT: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = hdma_pkg::RD_TABLE;
        state_next = S_CNT_CHK;
      end
      S_CNT_CHK: begin
        cmd.count_load = 1'b1;
        if (st.rdata_zero) begin
          cmd.stop   = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = hdma_pkg::RD_TABLE;
          idx_next   = 2'd0;
          state_next = st.indirect ? S_PLO : S_WR;
        end
      end
      S_PLO: begin
        cmd.lo_load = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = hdma_pkg::RD_TABLE;
        state_next  = S_PHI;
      end
      S_PHI: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = hdma_pkg::RD_FRESH;
        idx_next   = 2'd0;
        state_next = S_WR;
      end
      S_XFER: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = data_sel;
        idx_next   = 2'd0;
        state_next = S_WR;
      end
      S_WR: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = last;
          if (last) begin
            cmd.count_dec = 1'b1;
            state_next    = S_IDLE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = data_sel;
            idx_next   = idx + 2'd1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= 2'd0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/hdma_datapath.sv
`default_nettype none

module hdma_datapath #(
  parameter int unsigned MEM_ADDR_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire hdma_pkg::hdma_cmd_t                 cmd,
  output hdma_pkg::hdma_status_t                   st,
  input  wire logic [15:0]                         mem_address,
  input  wire logic [7:0]                          load_data,
  input  wire logic                                cfg_valid,
  input  wire logic [hdma_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [7:0]                          cfg_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [13:0]                              reg_address,
  output logic [7:0]                               reg_value,
  output logic                                     last_write
);

  localparam int unsigned MEM_DEPTH = 2 ** MEM_ADDR_BITS;

  logic [7:0]               mem [MEM_DEPTH];
  logic [7:0]               rdata;
  logic [MEM_ADDR_BITS-1:0] table_pointer;
  logic [MEM_ADDR_BITS-1:0] data_pointer;
  logic [MEM_ADDR_BITS-1:0] rd_addr;
  logic [MEM_ADDR_BITS-1:0] fresh_pointer;
  logic [MEM_ADDR_BITS-1:0] wr_addr;
  logic [7:0]               ptr_lo;
  logic [7:0]               repeat_count;
  logic                     running;
  logic [2:0]               transfer_mode;
  logic                     indirect_mode;
  logic [7:0]               register_base;
  logic                     out_free;

  assign fresh_pointer = MEM_ADDR_BITS'({rdata, ptr_lo});
  assign wr_addr       = MEM_ADDR_BITS'(mem_address);
  assign out_free      = !out_valid || out_ready;

  always_comb begin
    case (cmd.rd_sel)
      hdma_pkg::RD_TABLE: rd_addr = table_pointer;
      hdma_pkg::RD_DATA:  rd_addr = data_pointer;
      hdma_pkg::RD_FRESH: rd_addr = fresh_pointer;
      default:            rd_addr = table_pointer;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[wr_addr] <= load_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lo_load) begin
      ptr_lo <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_pointer <= '0;
      data_pointer  <= '0;
      repeat_count  <= 8'd0;
      running       <= 1'b0;
    end else begin
      if (cmd.start) begin
        table_pointer <= wr_addr;
        repeat_count  <= 8'd0;
        running       <= 1'b1;
      end
      if (cmd.stop) begin
        running <= 1'b0;
      end
      if (cmd.rd_en) begin
        case (cmd.rd_sel)
          hdma_pkg::RD_TABLE: table_pointer <= table_pointer + MEM_ADDR_BITS'(1);
          hdma_pkg::RD_DATA:  data_pointer  <= data_pointer + MEM_ADDR_BITS'(1);
          hdma_pkg::RD_FRESH: data_pointer  <= fresh_pointer + MEM_ADDR_BITS'(1);
          default: ;
        endcase
      end
      if (cmd.count_load) begin
        repeat_count <= rdata;
      end else if (cmd.count_dec) begin
        repeat_count <= repeat_count - 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      transfer_mode <= 3'd0;
      indirect_mode <= 1'b0;
      register_base <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        hdma_pkg::CFG_TRANSFER_MODE: transfer_mode <= cfg_data[2:0];
        hdma_pkg::CFG_INDIRECT_MODE: indirect_mode <= cfg_data[0];
        hdma_pkg::CFG_REGISTER_BASE: register_base <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      reg_address <= hdma_pkg::REG_PAGE + {6'd0, register_base}
                     + {12'd0, hdma_pkg::reg_offset(transfer_mode, cmd.wr_idx)};
      reg_value   <= rdata;
      last_write  <= cmd.out_last;
    end
  end

  always_comb begin
    st.running    = running;
    st.count      = repeat_count;
    st.rdata_zero = (rdata == 8'd0);
    st.indirect   = indirect_mode;
    st.mode       = transfer_mode;
    st.out_free   = out_free;
  end

endmodule

`default_nettype wire

FILE: rtl/core/hdma_line_transfer_engine.sv
`default_nettype none

// One table-driven transfer channel that turns a table in its local byte memory of
// 2**MEM_ADDR_BITS bytes into 1, 2 or 4 register writes per line transaction. Load, start
// and ignored transactions and a line that only counts down stay in the idle state. A line
// that starts a new direct entry reads its count byte, then its data bytes; a new indirect
// entry its count byte, two pointer bytes, then its data bytes; a repeated line only its
// data bytes, as many as the write count of the transfer mode. Every table and data byte
// goes through the single memory port with its registered read, one byte per cycle while
// the output channel does not stall. Input is taken only while no line is in progress; the
// last write of a line may still wait in the output register while the next one is taken.
// The memory is not cleared by reset, so reads must only touch loaded bytes. Configuration
// writes are accepted in every cycle and must only be issued while the channel is idle.
module hdma_line_transfer_engine #(
  parameter int unsigned MEM_ADDR_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          req_type,
  input  wire logic [15:0]                         mem_address,
  input  wire logic [7:0]                          load_data,
  input  wire logic                                channel_active,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [13:0]                              reg_address,
  output logic [7:0]                               reg_value,
  output logic                                     last_write,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [hdma_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [7:0]                          cfg_data
);

  hdma_pkg::hdma_cmd_t    cmd;
  hdma_pkg::hdma_status_t st;

  assign cfg_ready = 1'b1;

  hdma_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .channel_active (channel_active),
    .st             (st),
    .cmd            (cmd)
  );

  hdma_datapath #(
    .MEM_ADDR_BITS (MEM_ADDR_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .mem_address (mem_address),
    .load_data   (load_data),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .reg_address (reg_address),
    .reg_value   (reg_value),
    .last_write  (last_write)
  );

endmodule

`default_nettype wire

FILE: tb/sv/hdma_line_transfer_engine_tb.sv
module hdma_line_transfer_engine_tb;

  localparam logic [1:0] REQ_NONE = 2'd3;

  typedef enum {BYTE_COUNT, BYTE_POINTER, BYTE_DATA} byte_role_t;

  typedef struct packed {
    logic [13:0] addr;
    logic [7:0]  value;
    logic        is_last;
  } reg_write_t;

  class transfer_scoreboard;
    logic [7:0]     mem_bytes [logic [15:0]];
    logic [15:0]    table_ptr;
    logic [15:0]    data_ptr;
    logic [7:0]     repeat_left;
    bit             running;
    logic [2:0]     mode;
    bit             indirect;
    logic [7:0]     base;
    reg_write_t     expected_writes [$];
    int             mismatches;
    int unsigned    writes_per_line [8];
    logic [1:0]     lane_offset [8][4];

    function new();
      writes_per_line = '{1, 2, 2, 4, 4, 4, 2, 4};
      lane_offset = '{'{0, 0, 0, 0}, '{0, 1, 0, 1}, '{0, 0, 0, 0}, '{0, 0, 1, 1},
                      '{0, 1, 2, 3}, '{0, 1, 0, 1}, '{0, 0, 0, 0}, '{0, 0, 1, 1}};
      table_ptr = '0;
      data_ptr = '0;
      repeat_left = '0;
      running = 0;
      mode = '0;
      indirect = 0;
      base = '0;
      mismatches = 0;
    endfunction

    function void set_register(logic [hdma_pkg::CFG_INDEX_BITS-1:0] idx,
                               logic [7:0] value);
      case (idx)
        hdma_pkg::CFG_TRANSFER_MODE: mode = value[2:0];
        hdma_pkg::CFG_INDIRECT_MODE: indirect = value[0];
        hdma_pkg::CFG_REGISTER_BASE: base = value;
        default: ;
      endcase
    endfunction

    // Walks one line transaction. Without apply it only reports the first byte the line
    // would read that was never loaded; with apply it updates the channel state and
    // queues the register writes.
    function bit line_walk(input bit apply, output logic [15:0] gap, output byte_role_t role);
      logic [15:0] tp;
      logic [15:0] dp;
      logic [7:0]  rc;
      logic [7:0]  lo;
      logic [7:0]  hi;
      logic [7:0]  v;
      bit          fresh;
      int          n;
      int          j;
      tp = table_ptr;
      dp = data_ptr;
      rc = repeat_left;
      fresh = 0;
      gap = '0;
      role = BYTE_DATA;
      if (!running) return 0;
      if (rc[6:0] == 7'd0) begin
        gap = tp;
        role = BYTE_COUNT;
        if (!mem_bytes.exists(tp)) return 1;
        rc = mem_bytes[tp];
        tp++;
        if (rc == 8'd0) begin
          if (apply) begin
            table_ptr = tp;
            repeat_left = rc;
            running = 0;
          end
          return 0;
        end
        if (indirect) begin
          role = BYTE_POINTER;
          gap = tp;
          if (!mem_bytes.exists(tp)) return 1;
          lo = mem_bytes[tp];
          tp++;
          gap = tp;
          if (!mem_bytes.exists(tp)) return 1;
          hi = mem_bytes[tp];
          tp++;
          dp = {hi, lo};
        end
        fresh = 1;
      end
      if (fresh || rc[7]) begin
        n = writes_per_line[mode];
        role = BYTE_DATA;
        for (j = 0; j < n; j++) begin
          gap = indirect ? dp : tp;
          if (!mem_bytes.exists(gap)) return 1;
          v = mem_bytes[gap];
          if (indirect) dp++;
          else tp++;
          if (apply) begin
            expected_writes.push_back(reg_write_t'{hdma_pkg::REG_PAGE + 14'(base) +
                                                   14'(lane_offset[mode][j]), v, (j == n - 1)});
          end
        end
      end
      if (apply) begin
        table_ptr = tp;
        data_ptr = dp;
        repeat_left = rc - 8'd1;
      end
      return 0;
    endfunction

    function void note_input(logic [1:0] req, logic [15:0] addr, logic [7:0] data, logic act);
      logic [15:0] gap;
      byte_role_t  role;
      case (req)
        hdma_pkg::REQ_LOAD: mem_bytes[addr] = data;
        hdma_pkg::REQ_START: begin
          if (act) begin
            table_ptr = addr;
            repeat_left = '0;
            running = 1;
          end else begin
            running = 0;
          end
        end
        hdma_pkg::REQ_LINE: void'(line_walk(1'b1, gap, role));
        default: ;
      endcase
    endfunction

    function void check_write(logic [13:0] addr, logic [7:0] value, logic is_last);
      reg_write_t w;
      if (expected_writes.size() == 0) begin
        $error("unexpected register write: reg_address %h reg_value %h", addr, value);
        mismatches++;
        return;
      end
      w = expected_writes.pop_front();
      if (addr !== w.addr) begin
        $error("reg_address: expected %h, actual %h", w.addr, addr);
        mismatches++;
      end
      if (value !== w.value) begin
        $error("reg_value: expected %h, actual %h", w.value, value);
        mismatches++;
      end
      if (is_last !== w.is_last) begin
        $error("last_write: expected %b, actual %b", w.is_last, is_last);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return expected_writes.size();
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic [1:0]                          req_type = hdma_pkg::REQ_LOAD;
  logic [15:0]                         mem_address = '0;
  logic [7:0]                          load_data = '0;
  logic                                channel_active = 1'b0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [13:0]                         reg_address;
  logic [7:0]                          reg_value;
  logic                                last_write;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [hdma_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [7:0]                          cfg_data = '0;

  transfer_scoreboard sb = new();
  bit calm = 0;
  int items_sent = 0;
  int writes_taken = 0;
  int stall_left = 0;

  hdma_line_transfer_engine dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .mem_address(mem_address),
    .load_data(load_data),
    .channel_active(channel_active),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .reg_address(reg_address),
    .reg_value(reg_value),
    .last_write(last_write),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_write(reg_address, reg_value, last_write);
      writes_taken++;
      if (writes_taken == 60) stall_left = 400;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 31);
    end
  end

  task automatic send(input logic [1:0] req, input logic [15:0] addr, input logic [7:0] data,
                      input logic act);
    if (!calm) begin
      while ($urandom_range(0, 99) < 31) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    req_type <= req;
    mem_address <= addr;
    load_data <= data;
    channel_active <= act;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(req, addr, data, act);
    if (req != REQ_NONE) items_sent++;
  endtask

  // Loads every byte the next line would read but that holds nothing yet, then sends the line.
  task automatic send_line();
    logic [15:0] gap;
    byte_role_t  role;
    logic [7:0]  v;
    int          r;
    while (sb.line_walk(1'b0, gap, role)) begin
      r = $urandom_range(0, 99);
      if (role != BYTE_COUNT) v = 8'($urandom);
      else if (r < 6) v = 8'h00;
      else if (r < 90) v = {1'($urandom), 7'($urandom_range(1, 3))};
      else v = 8'($urandom);
      send(hdma_pkg::REQ_LOAD, gap, v, 1'($urandom));
    end
    send(hdma_pkg::REQ_LINE, 16'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic write_register(input logic [hdma_pkg::CFG_INDEX_BITS-1:0] idx,
                                input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, value);
  endtask

  task automatic write_config(input logic [2:0] mode, input logic ind, input logic [7:0] base);
    write_register(hdma_pkg::CFG_TRANSFER_MODE, 8'(mode));
    write_register(hdma_pkg::CFG_INDIRECT_MODE, 8'(ind));
    write_register(hdma_pkg::CFG_REGISTER_BASE, base);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic random_burst();
    int pick;
    logic [15:0] start_addr;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 5) == 0) start_addr = 16'($urandom_range(16'hFFF0, 16'hFFFF));
        else start_addr = 16'($urandom);
        send(hdma_pkg::REQ_START, start_addr, 8'($urandom), 1'b1);
      end
      repeat ($urandom_range(1, 10)) send_line();
    end else if (pick < 80) begin
      send(hdma_pkg::REQ_LOAD, 16'($urandom), 8'($urandom), 1'($urandom));
    end else if (pick < 87) begin
      send(hdma_pkg::REQ_START, 16'($urandom), 8'($urandom), 1'b0);
    end else if (pick < 94) begin
      send(REQ_NONE, 16'($urandom), 8'($urandom), 1'($urandom));
    end else begin
      send_line();
    end
  endtask

  initial begin
    int phase;
    int target;
    logic [7:0] base;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_config(3'd4, 1'b1, 8'hFF);

    send(hdma_pkg::REQ_LINE, 16'hFFFF, 8'hFF, 1'b1);
    send(REQ_NONE, 16'hFFFF, 8'hFF, 1'b1);
    send(hdma_pkg::REQ_START, 16'h0000, 8'h00, 1'b0);
    send_line();
    send(hdma_pkg::REQ_LOAD, 16'hFFFF, 8'h82, 1'b0);
    send(hdma_pkg::REQ_LOAD, 16'h0002, 8'h00, 1'b1);
    send(hdma_pkg::REQ_START, 16'hFFFF, 8'h00, 1'b1);
    send_line();
    send_line();
    send_line();
    send_line();
    send(hdma_pkg::REQ_LOAD, 16'h8000, 8'hFF, 1'b0);
    send(hdma_pkg::REQ_START, 16'h1234, 8'hAA, 1'b0);
    send(hdma_pkg::REQ_START, 16'h8000, 8'h55, 1'b1);
    send_line();
    send_line();

    for (phase = 0; phase < 16; phase++) begin
      drain();
      calm = (phase >= 5 && phase <= 7);
      if (phase == 0) base = 8'h00;
      else if (phase == 1 || phase == 15) base = 8'hFF;
      else base = 8'($urandom);
      write_config(3'(phase % 8), 1'(phase / 8), base);
      target = items_sent + 28;
      while (items_sent < target) random_burst();
    end

    drain();
    repeat (30) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("hdma_line_transfer_engine: match");
    end else begin
      $display("hdma_line_transfer_engine: mismatch");
    end
    $finish;
  end

  initial begin
    #12000000;
    $display("hdma_line_transfer_engine: mismatch");
    $finish;
  end

endmodule
